/* rtl/hir_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and limits for the hex image receiver.
// No dependencies; every other file imports this package.
package hir_pkg;

  localparam int CNT_W = 20;
  localparam int OFF_W = 19;

  localparam logic [31:0] MAX_IMAGE_BYTES = 32'd524288;
  localparam logic [7:0]  MAX_CHUNK_BYTES = 8'd128;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic [2:0] ACT_BEGIN       = 3'd0;
  localparam logic [2:0] ACT_CHUNK_START = 3'd1;
  localparam logic [2:0] ACT_HEX_CHAR    = 3'd2;
  localparam logic [2:0] ACT_CHUNK_END   = 3'd3;
  localparam logic [2:0] ACT_FINISH      = 3'd4;
  localparam logic [2:0] ACT_ABORT       = 3'd5;

  localparam logic CFG_IMAGE_LENGTH   = 1'b0;
  localparam logic CFG_IMAGE_CHECKSUM = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_RECEIVING = 2'd1,
    ST_READY     = 2'd2,
    ST_ERROR     = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [CNT_W-1:0] chunk_offset;
    logic [7:0]       hex_char;
  } in_word_t;

  typedef struct packed {
    logic             accepted;
    logic [1:0]       session_status;
    logic             write_valid;
    logic [OFF_W-1:0] write_offset;
    logic [7:0]       write_byte;
    logic [CNT_W-1:0] bytes_received;
    logic [31:0]      current_checksum;
    logic [31:0]      session_number;
  } out_word_t;

endpackage

/* rtl/hex_image_receiver.sv */
`timescale 1ns / 1ps
// Hex image receiver top level: configuration registers, pipeline and checks.
// Depends on hir_pkg, hir_in_stage, hir_session, hir_out_stage.
//
// This block runs a receive session for a firmware image sent as ASCII hex
// text, one word per action: begin, chunk start, hex character, chunk end,
// finish or abort. Every input word produces exactly one result word, which
// reports whether the action was taken, the session status, any decoded byte
// with its staging offset, the byte count, the running CRC-32 and the number
// of images finished so far. The block takes one word per clock cycle and
// keeps doing so while results flow out freely; an accepted word is held in
// the input register and its result is loaded into the result register, from
// which it is presented. One word per cycle is set by the session logic,
// which reads and updates its state, including a byte-wide CRC-32 fold, in
// logic that is combinational between the input and the result register.
// When out_stall is held, one word waits in the result register
// and one in the input register, after which in_stall rises. The image
// length and expected checksum registers are read live and should only be
// written while no words are in flight; cfg_ready is always high.
module hex_image_receiver
  import hir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,

  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] image_length_r;
  logic [31:0] image_checksum_r;

  logic        advance;
  logic        step;
  in_word_t    item;
  out_word_t   result;

  // Configuration writes are always taken, so the port never holds off.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_length_r   <= 32'd0;
      image_checksum_r <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_LENGTH:   image_length_r   <= cfg_data;
        CFG_IMAGE_CHECKSUM: image_checksum_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The input register holds the word the session logic is looking at.
  hir_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .advance  (advance),
    .step     (step),
    .item     (item)
  );

  // The session logic commits its state at the same edge at which its result
  // is loaded into the result register, so a following word sees the update.
  hir_session u_session (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .item           (item),
    .image_length   (image_length_r),
    .image_checksum (image_checksum_r),
    .result         (result)
  );

  hir_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  // A presented byte belongs to an accepted word in a live session, and the
  // count it reports has already moved one past its offset.
  a_write_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.write_valid) |->
      (out_word.accepted && out_word.session_status == ST_RECEIVING &&
       out_word.bytes_received == {1'b0, out_word.write_offset} + 20'd1))
    else $error("presented byte does not match the reported count");

  // The input side only holds off when both registers are full and blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register could drain");

  // Nothing is presented in the cycle after reset.
  a_empty_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("result presented straight after reset");
`endif

endmodule

/* rtl/hir_in_stage.sv */
`timescale 1ns / 1ps
// Input register of the hex image receiver: holds one word and drives in_stall.
// Depends on hir_pkg.
module hir_in_stage
  import hir_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     advance,
  output logic     step,
  output in_word_t item
);

  logic     valid_r, valid_nxt;
  in_word_t word_r;
  logic     accept;

  // A held word may leave whenever the stage behind it can take a result.
  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;
  assign step     = valid_r && advance;
  assign item     = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      word_r <= in_word;
    end
  end

endmodule

/* rtl/hir_crc_byte.sv */
`timescale 1ns / 1ps
// Folds one byte into a reflected CRC-32 register, one bit per step.
// Depends on hir_pkg for the polynomial.
module hir_crc_byte
  import hir_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

/* rtl/hir_session.sv */
`timescale 1ns / 1ps
// Session state and per-word decision logic of the hex image receiver.
// Depends on hir_pkg and hir_crc_byte.
module hir_session
  import hir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  in_word_t    item,
  input  logic [31:0] image_length,
  input  logic [31:0] image_checksum,
  output out_word_t   result
);

  status_t          status_r, status_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic [31:0]      finish_r, finish_nxt;
  logic             open_r, open_nxt;
  logic [7:0]       chunk_bytes_r, chunk_bytes_nxt;
  logic             pend_r, pend_nxt;
  logic [3:0]       high_r, high_nxt;

  logic             nib_ok;
  logic [3:0]       nib;
  logic [7:0]       byte_val;
  logic [31:0]      crc_folded;
  logic             ok, wv;
  logic             recv;

  // Hex digit decode, either case.
  always_comb begin
    nib_ok = 1'b1;
    nib    = 4'd0;
    if (item.hex_char >= 8'h30 && item.hex_char <= 8'h39) begin
      nib = 4'(item.hex_char - 8'h30);
    end else if (item.hex_char >= 8'h61 && item.hex_char <= 8'h66) begin
      nib = 4'(item.hex_char - 8'h57);
    end else if (item.hex_char >= 8'h41 && item.hex_char <= 8'h46) begin
      nib = 4'(item.hex_char - 8'h37);
    end else begin
      nib_ok = 1'b0;
    end
  end

  assign byte_val = {high_r, nib};
  assign recv     = (status_r == ST_RECEIVING);

  hir_crc_byte u_crc (
    .crc_in  (crc_r),
    .data    (byte_val),
    .crc_out (crc_folded)
  );

  always_comb begin
    status_nxt      = status_r;
    count_nxt       = count_r;
    crc_nxt         = crc_r;
    finish_nxt      = finish_r;
    open_nxt        = open_r;
    chunk_bytes_nxt = chunk_bytes_r;
    pend_nxt        = pend_r;
    high_nxt        = high_r;
    ok              = 1'b0;
    wv              = 1'b0;

    case (item.action)
      ACT_BEGIN: begin
        if (image_length != 32'd0 && image_length <= MAX_IMAGE_BYTES) begin
          status_nxt      = ST_RECEIVING;
          count_nxt       = '0;
          crc_nxt         = CRC_ONES;
          open_nxt        = 1'b0;
          chunk_bytes_nxt = 8'd0;
          pend_nxt        = 1'b0;
          high_nxt        = 4'd0;
          ok              = 1'b1;
        end
      end
      ACT_CHUNK_START: begin
        if (recv && !open_r && item.chunk_offset == count_r) begin
          open_nxt        = 1'b1;
          chunk_bytes_nxt = 8'd0;
          pend_nxt        = 1'b0;
          ok              = 1'b1;
        end
      end
      ACT_HEX_CHAR: begin
        if (recv && open_r && nib_ok) begin
          if (!pend_r) begin
            high_nxt = nib;
            pend_nxt = 1'b1;
            ok       = 1'b1;
          end else if (chunk_bytes_r < MAX_CHUNK_BYTES &&
                       {{(32-CNT_W){1'b0}}, count_r} < image_length) begin
            wv              = 1'b1;
            crc_nxt         = crc_folded;
            count_nxt       = count_r + 1'b1;
            chunk_bytes_nxt = chunk_bytes_r + 8'd1;
            pend_nxt        = 1'b0;
            ok              = 1'b1;
          end
        end
      end
      ACT_CHUNK_END: begin
        if (recv && open_r && !pend_r && chunk_bytes_r != 8'd0) begin
          open_nxt = 1'b0;
          ok       = 1'b1;
        end
      end
      ACT_FINISH: begin
        if (recv && !open_r &&
            {{(32-CNT_W){1'b0}}, count_r} == image_length &&
            (crc_r ^ CRC_ONES) == image_checksum) begin
          finish_nxt = finish_r + 32'd1;
          status_nxt = ST_READY;
          ok         = 1'b1;
        end
      end
      ACT_ABORT: begin
        status_nxt      = ST_IDLE;
        count_nxt       = '0;
        crc_nxt         = CRC_ONES;
        open_nxt        = 1'b0;
        chunk_bytes_nxt = 8'd0;
        pend_nxt        = 1'b0;
        high_nxt        = 4'd0;
        ok              = 1'b1;
      end
      default: begin
      end
    endcase

    // Any refused word of a defined action drops the session into error.
    if (!ok && item.action <= ACT_FINISH) begin
      status_nxt = ST_ERROR;
      open_nxt   = 1'b0;
      pend_nxt   = 1'b0;
    end
  end

  always_comb begin
    result.accepted         = ok;
    result.session_status   = status_nxt;
    result.write_valid      = wv;
    result.write_offset     = wv ? count_r[OFF_W-1:0] : '0;
    result.write_byte       = wv ? byte_val : 8'd0;
    result.bytes_received   = count_nxt;
    result.current_checksum = crc_nxt ^ CRC_ONES;
    result.session_number   = finish_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r      <= ST_IDLE;
      count_r       <= '0;
      crc_r         <= CRC_ONES;
      finish_r      <= 32'd0;
      open_r        <= 1'b0;
      chunk_bytes_r <= 8'd0;
      pend_r        <= 1'b0;
      high_r        <= 4'd0;
    end else if (step) begin
      status_r      <= status_nxt;
      count_r       <= count_nxt;
      crc_r         <= crc_nxt;
      finish_r      <= finish_nxt;
      open_r        <= open_nxt;
      chunk_bytes_r <= chunk_bytes_nxt;
      pend_r        <= pend_nxt;
      high_r        <= high_nxt;
    end
  end

endmodule

/* rtl/hir_out_stage.sv */
`timescale 1ns / 1ps
// Result register of the hex image receiver, with its valid flag.
// Depends on hir_pkg.
module hir_out_stage
  import hir_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_word_t result,
  output logic      advance,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      valid_r, valid_nxt;
  out_word_t word_r;

  assign advance   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      word_r <= result;
    end
  end

endmodule

/* dv/hex_image_receiver_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hex image receiver session block.
// Depends on hir_pkg and hex_image_receiver; needs nothing else to run.
module hex_image_receiver_tb;
  import hir_pkg::*;

  // Timing of the run.  The block answers once a word has passed its input
  // and result registers, so the drain cycles are plenty before register writes.
  localparam int          DRAIN_CYCLES  = 6;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          RANDOM_WORDS  = 1050;
  localparam int          MAX_PRINTED   = 40;

  // Action codes that the block must ignore.
  localparam logic [2:0]  ACT_SPARE_LO  = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI  = 3'd7;

  // Ways in which a generated image session may be spoilt on purpose.
  localparam int          FLAW_NONE     = 0;
  localparam int          FLAW_SUM      = 1;
  localparam int          FLAW_OVERRUN  = 2;
  localparam int          FLAW_LONG     = 3;
  localparam int          FLAW_NOISE    = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_word = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_word;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_IMAGE_LENGTH;
  logic [31:0] cfg_data = '0;

  hex_image_receiver i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Words waiting to be offered to the block, and the result words that the
  // block still owes us, oldest first.
  in_word_t    actions_to_send[$];
  out_word_t   receipts_due[$];

  // Our own copy of the session state, kept in step with every word that the
  // block takes.  Register copies change only when a configuration write is
  // seen on the bus.
  logic [31:0] image_len = '0;
  logic [31:0] image_sum = '0;
  status_t     sess_status = ST_IDLE;
  logic [19:0] byte_count = '0;
  logic [31:0] crc_copy = CRC_ONES;
  logic [31:0] images_done = '0;
  logic        chunk_is_open = 1'b0;
  logic [7:0]  chunk_fill = '0;
  logic        half_byte = 1'b0;
  logic [3:0]  high_half = '0;

  // Bookkeeping.
  int unsigned words_queued = 0;
  int unsigned words_taken = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct = 31;
  int unsigned rx_idle_pct = 49;
  bit          word_taken = 1'b0;

  // Reflected CRC-32, one byte folded in at a time.
  function automatic logic [31:0] crc_fold(logic [31:0] c, logic [7:0] b);
    int k;
    c = c ^ {24'd0, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_session();
    byte_count    = '0;
    crc_copy      = CRC_ONES;
    chunk_is_open = 1'b0;
    chunk_fill    = '0;
    half_byte     = 1'b0;
    high_half     = '0;
  endfunction

  // Works out the result word for one action and moves the session state on.
  function automatic out_word_t apply_action(in_word_t w);
    out_word_t  r;
    logic       ok;
    logic       receiving;
    int         nib;
    logic [7:0] b;
    r = '0;
    ok = 1'b0;
    nib = -1;
    receiving = (sess_status == ST_RECEIVING);
    case (w.action)
      ACT_BEGIN: begin
        if (image_len != 0 && image_len <= MAX_IMAGE_BYTES) begin
          clear_session();
          sess_status = ST_RECEIVING;
          ok = 1'b1;
        end
      end
      ACT_CHUNK_START: begin
        if (receiving && !chunk_is_open && w.chunk_offset == byte_count) begin
          chunk_is_open = 1'b1;
          chunk_fill = '0;
          half_byte = 1'b0;
          ok = 1'b1;
        end
      end
      ACT_HEX_CHAR: begin
        if (w.hex_char >= "0" && w.hex_char <= "9") nib = w.hex_char - "0";
        else if (w.hex_char >= "a" && w.hex_char <= "f") nib = w.hex_char - "a" + 10;
        else if (w.hex_char >= "A" && w.hex_char <= "F") nib = w.hex_char - "A" + 10;
        if (receiving && chunk_is_open && nib >= 0) begin
          if (!half_byte) begin
            // First character of a pair only sets the upper half.
            high_half = nib[3:0];
            half_byte = 1'b1;
            ok = 1'b1;
          end else if (chunk_fill < MAX_CHUNK_BYTES && {12'd0, byte_count} < image_len) begin
            b = {high_half, nib[3:0]};
            r.write_valid = 1'b1;
            r.write_offset = byte_count[OFF_W-1:0];
            r.write_byte = b;
            crc_copy = crc_fold(crc_copy, b);
            byte_count = byte_count + 20'd1;
            chunk_fill = chunk_fill + 8'd1;
            half_byte = 1'b0;
            ok = 1'b1;
          end
        end
      end
      ACT_CHUNK_END: begin
        if (receiving && chunk_is_open && !half_byte && chunk_fill != 0) begin
          chunk_is_open = 1'b0;
          ok = 1'b1;
        end
      end
      ACT_FINISH: begin
        if (receiving && !chunk_is_open && {12'd0, byte_count} == image_len &&
            ~crc_copy == image_sum) begin
          images_done = images_done + 32'd1;
          sess_status = ST_READY;
          ok = 1'b1;
        end
      end
      ACT_ABORT: begin
        sess_status = ST_IDLE;
        clear_session();
        ok = 1'b1;
      end
      default: ;
    endcase
    // A refused action drops the session into the error state; counts and
    // CRC stay as they were.  The spare codes leave everything alone.
    if (!ok && w.action <= ACT_FINISH) begin
      sess_status = ST_ERROR;
      chunk_is_open = 1'b0;
      half_byte = 1'b0;
    end
    r.accepted = ok;
    r.session_status = sess_status;
    r.bytes_received = byte_count;
    r.current_checksum = ~crc_copy;
    r.session_number = images_done;
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Sender side.  A new word is offered once the previous one has gone, and
  // held steady for as long as the block stalls it.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (actions_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= actions_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver side: random back-pressure on the result channel.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
  end

  // Everything is sampled at the rising edge: register writes update our
  // copies, taken words are predicted, and delivered results are checked
  // against the oldest prediction.
  always @(posedge clk) begin : watch
    out_word_t want;
    out_word_t got;
    string     diffs;
    word_taken = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_LENGTH:   image_len = cfg_data;
          CFG_IMAGE_CHECKSUM: image_sum = cfg_data;
          default: ;
        endcase
        reg_writes++;
      end
      if (in_valid && !in_stall) begin
        word_taken = 1'b1;
        words_taken++;
        receipts_due.push_back(apply_action(in_word));
      end
      if (out_valid && !out_stall) begin
        if (receipts_due.size() == 0) begin
          report_mismatch("result word arrived with nothing outstanding");
        end else begin
          want = receipts_due.pop_front();
          got = out_word;
          results_checked++;
          diffs = "";
          if (got.accepted !== want.accepted)
            diffs = {diffs, $sformatf(" accepted %0d/%0d", got.accepted, want.accepted)};
          if (got.session_status !== want.session_status)
            diffs = {diffs, $sformatf(" status %0d/%0d", got.session_status,
                                      want.session_status)};
          if (got.write_valid !== want.write_valid)
            diffs = {diffs, $sformatf(" write_valid %0d/%0d", got.write_valid,
                                      want.write_valid)};
          if (got.write_offset !== want.write_offset)
            diffs = {diffs, $sformatf(" write_offset %0h/%0h", got.write_offset,
                                      want.write_offset)};
          if (got.write_byte !== want.write_byte)
            diffs = {diffs, $sformatf(" write_byte %0h/%0h", got.write_byte,
                                      want.write_byte)};
          if (got.bytes_received !== want.bytes_received)
            diffs = {diffs, $sformatf(" bytes %0d/%0d", got.bytes_received,
                                      want.bytes_received)};
          if (got.current_checksum !== want.current_checksum)
            diffs = {diffs, $sformatf(" crc %08h/%08h", got.current_checksum,
                                      want.current_checksum)};
          if (got.session_number !== want.session_number)
            diffs = {diffs, $sformatf(" session %0d/%0d", got.session_number,
                                      want.session_number)};
          if (diffs != "")
            report_mismatch($sformatf("result %0d (got/want):%s", results_checked, diffs));
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("hex_image_receiver regression: fail");
    $finish;
  end

  // Word builders.  Fields that an action does not use carry random values so
  // that every input bit is exercised.
  function automatic in_word_t action_word(logic [2:0] a);
    in_word_t w;
    w.action = a;
    w.chunk_offset = $urandom_range(20'hFFFFF);
    w.hex_char = $urandom_range(255);
    return w;
  endfunction

  function automatic in_word_t start_word(logic [19:0] off);
    in_word_t w;
    w = action_word(ACT_CHUNK_START);
    w.chunk_offset = off;
    return w;
  endfunction

  function automatic in_word_t char_word(logic [7:0] ch);
    in_word_t w;
    w = action_word(ACT_HEX_CHAR);
    w.hex_char = ch;
    return w;
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'("0") + n;
    return (upper ? 8'("A") : 8'("a")) + n - 8'd10;
  endfunction

  // A stray word of any kind, used to break otherwise sound sessions.
  function automatic in_word_t noise_word();
    in_word_t    w;
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: w = char_word(r[7:0]);
      1: w = action_word(ACT_CHUNK_START);
      2: w = action_word(r[0] ? ACT_SPARE_HI : ACT_SPARE_LO);
      3: w = action_word(ACT_CHUNK_END);
      4: w = action_word(ACT_FINISH);
      5: w = action_word(ACT_BEGIN);
      6: w = action_word(ACT_ABORT);
      default: w = r[30:0];
    endcase
    return w;
  endfunction

  task automatic queue_word(in_word_t w);
    actions_to_send.push_back(w);
    words_queued++;
  endtask

  // Waits until every queued word has been taken and answered, then lets the
  // pipeline settle so that a register write cannot meet a word in flight.
  task automatic wait_idle();
    do @(posedge clk);
    while (actions_to_send.size() != 0 || in_valid || receipts_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] len, logic [31:0] sum);
    wait_idle();
    write_reg(CFG_IMAGE_LENGTH, len);
    write_reg(CFG_IMAGE_CHECKSUM, sum);
  endtask

  // One image session: random image bytes, begin, chunks of random size with
  // the right offsets, hex text in mixed case, finish, at times an abort.  The registers are
  // set to match the image unless the session is spoilt on purpose.
  task automatic image_session(int unsigned len, int unsigned max_chunk, int flaw);
    logic [7:0]  img[$];
    in_word_t    script[$];
    logic [31:0] crc;
    logic [31:0] sum;
    int unsigned pos;
    int unsigned n;
    int unsigned k;
    crc = CRC_ONES;
    repeat (len) begin
      img.push_back($urandom_range(255));
      crc = crc_fold(crc, img[img.size()-1]);
    end
    script.push_back(action_word(ACT_BEGIN));
    pos = 0;
    while (pos < len) begin
      n = ($urandom_range(3) == 0) ? max_chunk : $urandom_range(max_chunk, 1);
      if (flaw == FLAW_LONG && pos == 0) n = $urandom_range(len, MAX_CHUNK_BYTES + 1);
      if (n > len - pos) n = len - pos;
      script.push_back(start_word(20'(pos)));
      for (k = pos; k < pos + n; k++) begin
        script.push_back(char_word(hex_digit(img[k][7:4], $urandom_range(1))));
        script.push_back(char_word(hex_digit(img[k][3:0], $urandom_range(1))));
      end
      script.push_back(action_word(ACT_CHUNK_END));
      pos += n;
    end
    script.push_back(action_word(ACT_FINISH));
    if ($urandom_range(9) == 0) script.push_back(action_word(ACT_ABORT));
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(3, 1))
        script.insert($urandom_range(script.size() - 1), noise_word());
    end
    sum = ~crc;
    if (flaw == FLAW_SUM) sum = sum ^ (32'h1 << $urandom_range(31));
    set_regs((flaw == FLAW_OVERRUN) ? len - 1 : len, sum);
    foreach (script[i]) queue_word(script[i]);
  endtask

  initial begin : stimulus
    int unsigned len;
    int unsigned roll;
    int          flaw;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.  With the reset registers the size is zero, so begin is
    // refused; actions outside a session are refused and spare codes ignored.
    queue_word(action_word(ACT_BEGIN));
    queue_word(start_word('0));
    queue_word(action_word(ACT_SPARE_LO));
    queue_word(action_word(ACT_SPARE_HI));

    // Sizes above the image limit are refused, the largest one included.
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(action_word(ACT_BEGIN));
    set_regs(MAX_IMAGE_BYTES + 32'd1, 32'h0);
    queue_word(action_word(ACT_BEGIN));

    // Largest legal size: offset mismatch, a second start with a chunk open,
    // a character that is not hex, and an empty chunk.
    set_regs(MAX_IMAGE_BYTES, 32'h0);
    queue_word(action_word(ACT_BEGIN));
    queue_word(start_word(20'h80000));
    queue_word(action_word(ACT_BEGIN));
    queue_word(start_word('0));
    queue_word(start_word('0));
    queue_word(action_word(ACT_BEGIN));
    queue_word(start_word('0));
    queue_word(char_word("g"));
    queue_word(action_word(ACT_BEGIN));
    queue_word(start_word('0));
    queue_word(action_word(ACT_CHUNK_END));

    // A complete two-byte image in mixed case that finishes cleanly, then a
    // finish in the ready state, which is refused, and an abort back to idle.
    set_regs(32'd2, ~crc_fold(crc_fold(CRC_ONES, 8'hFA), 8'h9C));
    queue_word(action_word(ACT_BEGIN));
    queue_word(start_word('0));
    queue_word(char_word("F"));
    queue_word(char_word("a"));
    queue_word(char_word("9"));
    queue_word(char_word("C"));
    queue_word(action_word(ACT_CHUNK_END));
    queue_word(action_word(ACT_FINISH));
    queue_word(action_word(ACT_FINISH));
    queue_word(action_word(ACT_ABORT));

    // Random part.  Two long sessions first so that the chunk limit is both
    // reached and passed, then mostly short sound sessions with some spoilt.
    image_session(130, 128, FLAW_LONG);
    image_session(140, 128, FLAW_NONE);
    while (words_queued < RANDOM_WORDS + 27) begin
      if (words_queued < 380) begin
        tx_idle_pct = 31;
        rx_idle_pct = 49;
      end else if (words_queued < 760) begin
        tx_idle_pct = 49;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        image_session($urandom_range(200, 100), 128, FLAW_NONE);
      end else begin
        len = $urandom_range(24, 2);
        roll = $urandom_range(99);
        if (roll < 55)      flaw = FLAW_NONE;
        else if (roll < 67) flaw = FLAW_SUM;
        else if (roll < 79) flaw = FLAW_OVERRUN;
        else                flaw = FLAW_NOISE;
        image_session(len, $urandom_range(12, 1), flaw);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (receipts_due.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", receipts_due.size()));

    $display("Sent %0d action words over %0d register writes; %0d results checked.",
             words_taken, reg_writes, results_checked);
    $display("Images finished: %0d; mismatching results: %0d.", images_done, mismatch_count);
    if (mismatch_count == 0) begin
      $display("hex_image_receiver regression: pass");
    end else begin
      $display("hex_image_receiver regression: fail");
    end
    $finish;
  end

endmodule
